[rtl/mbp_pkg.sv]
// Shared types, codes and helpers for the MIDI byte stream event parser.
// No dependencies; imported by mbp_decode and midi_byte_stream_event_parser.
package mbp_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0]       byte_t;
  typedef logic [1:0]       fill_t;   // queued bytes, at most three
  typedef logic [15:0]      bend_t;

  // status high nibble codes
  localparam logic [3:0] TYP_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYP_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYP_POLY     = 4'hA;
  localparam logic [3:0] TYP_CTRL     = 4'hB;
  localparam logic [3:0] TYP_PROG     = 4'hC;
  localparam logic [3:0] TYP_CHPRS    = 4'hD;
  localparam logic [3:0] TYP_BEND     = 4'hE;

  localparam byte_t CLOCK_BYTE = 8'hF8;

  // emitted event kinds
  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_BEND     = 2'd2;

  // verdict for one pass over the ring head
  typedef struct packed {
    logic       emit;
    logic       is_bend;
    logic [1:0] kind;
    logic [3:0] chan;
    byte_t      db1;
    byte_t      db2;
    bend_t      bend;
    fill_t      pops;
  } mbp_dec_t;

  // ring pointer advance, wraps at RING_DEPTH (inc stays below the depth)
  function automatic ptr_t ptr_add(ptr_t p, logic [1:0] inc);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {{(PTR_W-1){1'b0}}, inc};
    if (s >= (PTR_W+1)'(RING_DEPTH)) begin
      s = s - (PTR_W+1)'(RING_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

[rtl/mbp_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mbp_decode.sv]
// Message framing decision over the three ring head bytes.
// Depends on mbp_pkg.
module mbp_decode (
  input  mbp_pkg::byte_t   h0,
  input  mbp_pkg::byte_t   h1,
  input  mbp_pkg::byte_t   h2,
  input  mbp_pkg::fill_t   fill_push,  // queued bytes including the new one
  output mbp_pkg::mbp_dec_t dec
);
  import mbp_pkg::*;

  logic [3:0] typ;
  logic       three;
  logic       two;
  logic       known;
  logic       msg;

  assign typ   = h0[7:4];
  assign three = typ inside {TYP_NOTE_OFF, TYP_NOTE_ON, TYP_POLY, TYP_CTRL, TYP_BEND};
  assign two   = typ inside {TYP_PROG, TYP_CHPRS};
  assign known = typ inside {TYP_NOTE_OFF, TYP_NOTE_ON, TYP_CHPRS, TYP_BEND};

  always_comb begin
    msg          = 1'b0;
    dec          = '0;
    dec.chan     = h0[3:0];
    dec.db1      = h1;
    dec.db2      = three ? h2 : 8'd0;
    dec.bend     = {8'd0, h1} + {1'b0, h2, 7'd0};
    if (three && fill_push == 2'd3) begin
      msg      = 1'b1;
      dec.pops = 2'd3;
    end else if (two && fill_push >= 2'd2) begin
      msg = 1'b1;
      // one byte left behind may be a clock byte
      dec.pops = (fill_push == 2'd3 && h2 == CLOCK_BYTE) ? 2'd3 : 2'd2;
    end else begin
      // clock skip, or drop an unusable head once three bytes wait
      dec.pops = (h0 == CLOCK_BYTE || (fill_push == 2'd3 && !known)) ? 2'd1 : 2'd0;
    end
    dec.emit    = msg && (typ inside {TYP_NOTE_OFF, TYP_NOTE_ON, TYP_BEND});
    dec.is_bend = msg && (typ == TYP_BEND);
    case (typ)
      TYP_NOTE_ON: dec.kind = KIND_NOTE_ON;
      TYP_BEND:    dec.kind = KIND_BEND;
      default:     dec.kind = KIND_NOTE_OFF;
    endcase
  end

endmodule

[rtl/midi_byte_stream_event_parser.sv]
// Top level of the MIDI byte stream event parser: sequencer, ring RAM, result register.
// Depends on mbp_pkg, mbp_ram and mbp_decode.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  --------+-----+-------------------------------------------------+-----------
//  in_     | in  | midi_byte[7:0]                                  | suppress
//  out_    | out | channel[3:0] note[11:4] velocity[19:12] bend[35:20] | event_kind
//
// For each stored byte, head reads at rp, rp+1, rp+2 go out one per cycle on the single
// RAM read port; the next request is taken in the cycle the third byte lands, unless the
// commit waits. A request with suppress set is accepted and changes nothing.
// Reset (rst_n low, synchronous) empties the ring by clearing pointers and fill count;
// the RAM itself is not cleared.
// The finishing cycle waits only when an event is due and the result register is still
// full; in idle the input side stays open while a result waits in that register.
module midi_byte_stream_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // midi_byte[7:0]
  input  logic        in_tuser,   // suppress
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // channel, note_number, velocity, bend_value, zero pad
  output logic [1:0]  out_tuser   // event_kind
);
  import mbp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_H0   = 2'd1;  // head byte arriving
  localparam logic [1:0] ST_H1   = 2'd2;  // second byte arriving
  localparam logic [1:0] ST_FIN  = 2'd3;  // third byte arriving, decide and commit

  logic [1:0] st_r, st_nxt;
  ptr_t       rp_r, rp_nxt;
  ptr_t       wp_r, wp_nxt;
  fill_t      fill_r, fill_nxt;    // queued bytes before the request in flight
  bend_t      last_bend_r, last_bend_nxt;
  byte_t      byte_r;              // the byte in flight, for forwarding
  byte_t      h0_r, h1_r;
  byte_t      h0_fwd, h1_fwd, h2_fwd;

  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [3:0] out_chan_r;
  byte_t      out_db1_r, out_db2_r;
  bend_t      out_bend_r;

  byte_t      ram_rdata;
  ptr_t       ram_raddr;
  logic       in_acc;
  logic       push;
  logic       slot_free;
  logic       fin_ok;
  fill_t      fill_push;
  mbp_dec_t   dec;

  assign fill_push = fill_r + 2'd1;
  assign slot_free = !out_valid_r || out_tready;
  assign fin_ok    = !dec.emit || slot_free;
  assign in_tready = (st_r == ST_IDLE) || (st_r == ST_FIN && fin_ok);
  assign in_acc    = in_tvalid && in_tready;
  assign push      = in_acc && !in_tuser;

  // The slot at index fill_r holds the byte in flight; its RAM read may predate the write.
  assign h0_fwd = (fill_r == 2'd0) ? byte_r : h0_r;
  assign h1_fwd = (fill_r == 2'd1) ? byte_r : h1_r;
  assign h2_fwd = (fill_r == 2'd2) ? byte_r : ram_rdata;

  mbp_decode u_decode (
    .h0        (h0_fwd),
    .h1        (h1_fwd),
    .h2        (h2_fwd),
    .fill_push (fill_push),
    .dec       (dec)
  );

  // read address: head at accept, then head+1 and head+2;
  // the head+2 read is held while the commit waits on the result register
  always_comb begin
    case (st_r)
      ST_H0:   ram_raddr = ptr_add(rp_r, 2'd1);
      ST_H1:   ram_raddr = ptr_add(rp_r, 2'd2);
      ST_FIN:  ram_raddr = fin_ok ? rp_nxt : ptr_add(rp_r, 2'd2);
      default: ram_raddr = rp_r;
    endcase
  end

  mbp_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (wp_r),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_nxt        = st_r;
    rp_nxt        = rp_r;
    wp_nxt        = push ? ptr_add(wp_r, 2'd1) : wp_r;
    fill_nxt      = fill_r;
    last_bend_nxt = last_bend_r;
    case (st_r)
      ST_IDLE: begin
        if (push) begin
          st_nxt = ST_H0;
        end
      end
      ST_H0:   st_nxt = ST_H1;
      ST_H1:   st_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_ok) begin
          rp_nxt   = ptr_add(rp_r, dec.pops);
          fill_nxt = fill_push - dec.pops;
          if (dec.is_bend) begin
            last_bend_nxt = dec.bend;
          end
          st_nxt = push ? ST_H0 : ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      last_bend_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      last_bend_r <= last_bend_nxt;
      if (st_r == ST_FIN && fin_ok && dec.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      byte_r <= in_tdata;
    end
    if (st_r == ST_H0) begin
      h0_r <= ram_rdata;
    end
    if (st_r == ST_H1) begin
      h1_r <= ram_rdata;
    end
    if (st_r == ST_FIN && fin_ok && dec.emit) begin
      out_kind_r <= dec.kind;
      out_chan_r <= dec.chan;
      out_db1_r  <= dec.db1;
      out_db2_r  <= dec.db2;
      out_bend_r <= dec.is_bend ? dec.bend : last_bend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'd0, out_bend_r, out_db2_r, out_db1_r, out_chan_r};

  // the ring never holds more than two bytes between requests
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("ring fill exceeds two between requests");

  // pointers agree with the fill count while idle
  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (ptr_add(rp_r, fill_r) == wp_r))
    else $error("read/write pointers disagree with fill count");

  // a decision never pops more than is queued
  a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN) |-> (dec.pops <= fill_push))
    else $error("pop count exceeds queued bytes");

  // a committed event shows up in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && fin_ok && dec.emit) |=> out_valid_r)
    else $error("committed event not presented");

endmodule
